@@ src/dpcr_pkg.sv @@
// Shared types and constants for the depth pixel correct and rescale block.
package dpcr_pkg;

  // Configuration register indexes
  typedef enum logic [3:0] {
    REG_FRAME_WIDTH   = 4'd0,
    REG_FRAME_HEIGHT  = 4'd1,
    REG_RADIUS_SQ     = 4'd2,
    REG_DEPTH_CUR     = 4'd3,
    REG_OFFSET_CUR    = 4'd4,
    REG_DEPTH_NEW     = 4'd5,
    REG_OFFSET_NEW    = 4'd6,
    REG_MAX_INTENSITY = 4'd7
  } reg_idx_t;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 40;

  localparam logic [10:0] FRAME_WIDTH_RST   = 11'd320;
  localparam logic [10:0] FRAME_HEIGHT_RST  = 11'd240;
  localparam logic [39:0] RADIUS_SQ_RST     = 40'd19660800;
  localparam logic [15:0] DEPTH_CUR_RST     = 16'd1000;
  localparam logic [15:0] OFFSET_CUR_RST    = 16'd0;
  localparam logic [15:0] DEPTH_NEW_RST     = 16'd1000;
  localparam logic [15:0] OFFSET_NEW_RST    = 16'd0;
  localparam logic [15:0] MAX_INTENSITY_RST = 16'd65535;

  localparam logic [15:0] VALUE_MAX = 16'hFFFF;

  typedef struct packed {
    logic [9:0]  pixel_row;
    logic [9:0]  pixel_col;
    logic [15:0] pixel_value;
  } pix_in_t;

  typedef struct packed {
    logic [15:0] out_value;
    logic        clamped;
  } pix_out_t;

  typedef struct packed {
    logic [10:0] frame_width;
    logic [10:0] frame_height;
    logic [39:0] radius_sq;
    logic [15:0] depth_cur;
    logic [15:0] offset_cur;
    logic [15:0] depth_new;
    logic [15:0] offset_new;
    logic [15:0] max_intensity;
  } cfg_t;

endpackage

@@ src/tof_depth_pixel_correct_rescale_unit.sv @@
// Top level: settings registers, falloff correction and depth rescale pipeline.
//
// Pixels enter on in_valid/in_ready as one beat each (row, column, sample)
// and leave on out_valid/out_ready as one beat each (value, clamped flag).
// Every input beat yields exactly one output beat, in order.
// Settings are written through cfg_we/cfg_index/cfg_data, one register per
// cycle, and must only change while no pixel is in flight.
// From input accept to output valid a pixel passes three stages of
// offset, square and denominator work, a 16-stage divider for the falloff,
// two stages of scale and numerator, a second 16-stage divider, a saturate
// stage and the output register.
// Throughput is one pixel per cycle; each divider stage resolves one bit.
// The whole pipeline advances together whenever the output register is
// empty or being taken, so a receiver stall holds every stage in place and
// in_ready drops until the output beat is taken.
// Reset clears all valid bits and loads the default settings.
module tof_depth_pixel_correct_rescale_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [dpcr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dpcr_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  dpcr_pkg::pix_in_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output dpcr_pkg::pix_out_t                  out_data
);
  import dpcr_pkg::*;

  cfg_t cfg;

  // settings registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_width   <= FRAME_WIDTH_RST;
      cfg.frame_height  <= FRAME_HEIGHT_RST;
      cfg.radius_sq     <= RADIUS_SQ_RST;
      cfg.depth_cur     <= DEPTH_CUR_RST;
      cfg.offset_cur    <= OFFSET_CUR_RST;
      cfg.depth_new     <= DEPTH_NEW_RST;
      cfg.offset_new    <= OFFSET_NEW_RST;
      cfg.max_intensity <= MAX_INTENSITY_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_WIDTH:   cfg.frame_width   <= cfg_data[10:0];
        REG_FRAME_HEIGHT:  cfg.frame_height  <= cfg_data[10:0];
        REG_RADIUS_SQ:     cfg.radius_sq     <= cfg_data[39:0];
        REG_DEPTH_CUR:     cfg.depth_cur     <= cfg_data[15:0];
        REG_OFFSET_CUR:    cfg.offset_cur    <= cfg_data[15:0];
        REG_DEPTH_NEW:     cfg.depth_new     <= cfg_data[15:0];
        REG_OFFSET_NEW:    cfg.offset_new    <= cfg_data[15:0];
        REG_MAX_INTENSITY: cfg.max_intensity <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // global pipeline advance
  logic en;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  logic        fo_vld;
  logic [15:0] fo_corr;

  dpcr_falloff u_falloff (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .cfg       (cfg),
    .out_valid (fo_vld),
    .corr      (fo_corr)
  );

  dpcr_rescale u_rescale (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (fo_vld),
    .corr      (fo_corr),
    .cfg       (cfg),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

@@ src/dpcr_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, with sideband.
module dpcr_div #(
  parameter int NUM_W = 57,
  parameter int DEN_W = 41,
  parameter int QUO_W = 16,
  parameter int SB_W  = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  input  logic [SB_W-1:0]  sb_in,
  output logic             out_valid,
  output logic [QUO_W-1:0] quo,
  output logic [SB_W-1:0]  sb_out
);
  import dpcr_pkg::*;

  localparam int XW = NUM_W + 1;

  logic [NUM_W-1:0] rem_s [QUO_W+1];
  logic [DEN_W-1:0] den_s [QUO_W+1];
  logic [QUO_W-1:0] quo_s [QUO_W+1];
  logic [SB_W-1:0]  sb_s  [QUO_W+1];
  logic             vld_s [QUO_W+1];

  assign rem_s[0] = num;
  assign den_s[0] = den;
  assign quo_s[0] = '0;
  assign sb_s[0]  = sb_in;
  assign vld_s[0] = in_valid;

  // Each stage tries the divisor shifted to its quotient bit
  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    localparam int Sh = QUO_W - 1 - k;
    logic [XW-1:0] dsh;
    logic [XW-1:0] diff;

    assign dsh  = XW'(den_s[k]) << Sh;
    assign diff = {1'b0, rem_s[k]} - dsh;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_s[k+1] <= 1'b0;
      end else if (en) begin
        vld_s[k+1] <= vld_s[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_s[k+1] <= diff[NUM_W] ? rem_s[k] : diff[NUM_W-1:0];
        den_s[k+1] <= den_s[k];
        quo_s[k+1] <= {quo_s[k][QUO_W-2:0], ~diff[NUM_W]};
        sb_s[k+1]  <= sb_s[k];
      end
    end
  end

  assign out_valid = vld_s[QUO_W];
  assign quo       = quo_s[QUO_W];
  assign sb_out    = sb_s[QUO_W];

endmodule

@@ src/dpcr_falloff.sv @@
// Radial falloff: c = floor(p * R / (R + 256 * d2)), pipelined.
module dpcr_falloff (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  dpcr_pkg::pix_in_t in_data,
  input  dpcr_pkg::cfg_t    cfg,
  output logic              out_valid,
  output logic [15:0]       corr
);
  import dpcr_pkg::*;

  // stage A: offsets from the optical center
  logic               a_vld;
  logic signed [11:0] a_dx, a_dy;
  logic [15:0]        a_p;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else if (en) begin
      a_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_dx <= $signed({2'b00, cfg.frame_width[10:1]}) - $signed({2'b00, in_data.pixel_col})
              - 12'sd1;
      a_dy <= $signed({2'b00, cfg.frame_height[10:1]}) - $signed({2'b00, in_data.pixel_row})
              - 12'sd1;
      a_p  <= in_data.pixel_value;
    end
  end

  // stage B: squared distance and numerator product
  logic signed [23:0] sq_x, sq_y;
  logic               b_vld;
  logic [21:0]        b_d2;
  logic [55:0]        b_num;
  logic [15:0]        b_p;

  assign sq_x = a_dx * a_dx;
  assign sq_y = a_dy * a_dy;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld <= 1'b0;
    end else if (en) begin
      b_vld <= a_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_d2  <= sq_x[21:0] + sq_y[21:0];
      b_num <= 56'(a_p) * 56'(cfg.radius_sq);
      b_p   <= a_p;
    end
  end

  // stage C: denominator
  logic        c_vld;
  logic [40:0] c_den;
  logic [55:0] c_num;
  logic [15:0] c_p;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_vld <= 1'b0;
    end else if (en) begin
      c_vld <= b_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_den <= 41'(cfg.radius_sq) + 41'({b_d2, 8'h00});
      c_num <= b_num;
      c_p   <= b_p;
    end
  end

  // divider; a zero denominator passes the sample through
  logic [16:0] d_sb;
  logic [15:0] d_quo;

  dpcr_div #(
    .NUM_W (57),
    .DEN_W (41),
    .QUO_W (16),
    .SB_W  (17)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (c_vld),
    .num       ({1'b0, c_num}),
    .den       (c_den),
    .sb_in     ({c_den == 41'd0, c_p}),
    .out_valid (out_valid),
    .quo       (d_quo),
    .sb_out    (d_sb)
  );

  assign corr = d_sb[16] ? d_sb[15:0] : d_quo;

endmodule

@@ src/dpcr_rescale.sv @@
// Depth range rescale with saturation and zero rule, ending in the output register.
module dpcr_rescale (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  logic [15:0]        corr,
  input  dpcr_pkg::cfg_t     cfg,
  output logic               out_valid,
  output dpcr_pkg::pix_out_t out_data
);
  import dpcr_pkg::*;

  // settings-derived terms, steady while pixels flow
  logic signed [33:0] t_r;
  logic               skip_r;

  always_ff @(posedge clk) begin
    t_r    <= ($signed({1'b0, cfg.offset_cur}) - $signed({1'b0, cfg.offset_new}))
              * $signed({1'b0, cfg.max_intensity});
    skip_r <= (cfg.depth_cur == cfg.depth_new) && (cfg.offset_cur == cfg.offset_new);
  end

  // stage E: scale product
  logic        e_vld;
  logic [31:0] e_cd;
  logic [15:0] e_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_vld <= 1'b0;
    end else if (en) begin
      e_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_cd <= 32'(corr) * 32'(cfg.depth_cur);
      e_c  <= corr;
    end
  end

  // stage F: signed numerator
  logic               f_vld;
  logic signed [34:0] f_n;
  logic [15:0]        f_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_vld <= 1'b0;
    end else if (en) begin
      f_vld <= e_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_n <= $signed({3'b000, e_cd}) + 35'(t_r);
      f_c <= e_c;
    end
  end

  // range flags ahead of the divider
  logic f_neg, f_pos, f_over;

  assign f_neg  = f_n[34];
  assign f_pos  = !f_n[34] && (f_n != 35'sd0);
  assign f_over = !f_n[34] && (f_n[33:0] >= {2'b00, cfg.depth_new, 16'h0000});

  logic        d_vld;
  logic [15:0] d_quo;
  logic [18:0] d_sb;

  dpcr_div #(
    .NUM_W (33),
    .DEN_W (16),
    .QUO_W (16),
    .SB_W  (19)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (f_vld),
    .num       (f_n[32:0]),
    .den       (cfg.depth_new),
    .sb_in     ({f_neg, f_pos, f_over, f_c}),
    .out_valid (d_vld),
    .quo       (d_quo),
    .sb_out    (d_sb)
  );

  // stage H: saturation and back product for the zero rule
  logic [15:0] q_sel;
  logic        h_vld;
  logic [15:0] h_q;
  logic [31:0] h_qdn;
  logic        h_clamp, h_pos;
  logic [15:0] h_c;

  always_comb begin
    if (d_sb[18]) begin
      q_sel = 16'd0;
    end else if (d_sb[16]) begin
      q_sel = VALUE_MAX;
    end else begin
      q_sel = d_quo;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      h_vld <= 1'b0;
    end else if (en) begin
      h_vld <= d_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h_q     <= q_sel;
      h_qdn   <= 32'(q_sel) * 32'(cfg.depth_new);
      h_clamp <= d_sb[18] | d_sb[16];
      h_pos   <= d_sb[17];
      h_c     <= d_sb[15:0];
    end
  end

  // output register
  pix_out_t res;
  logic     zero_hit;

  assign zero_hit = !t_r[33] && (t_r[32:0] == {1'b0, h_qdn});

  always_comb begin
    if (skip_r) begin
      res.out_value = h_c;
      res.clamped   = 1'b0;
    end else if (cfg.depth_new == 16'd0) begin
      res.out_value = h_pos ? VALUE_MAX : 16'd0;
      res.clamped   = 1'b1;
    end else begin
      res.out_value = zero_hit ? 16'd0 : h_q;
      res.clamped   = h_clamp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= h_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= res;
    end
  end

endmodule

@@ tb/sv/dpcr_checker.sv @@
// Checker for the depth pixel correct and rescale block: predicts and compares output beats.
`timescale 1ns / 100ps

module dpcr_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [3:0]          cfg_index,
  input  logic [39:0]         cfg_data,
  input  logic                in_valid,
  input  logic                in_ready,
  input  dpcr_pkg::pix_in_t   in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  dpcr_pkg::pix_out_t  out_data,
  output int                  fail_count,
  output int                  pending_count,
  output int                  beats_seen
);
  import dpcr_pkg::*;

  cfg_t settings;
  pix_out_t expected_q[$];

  // Falloff correction followed by the optional depth rescale
  function automatic pix_out_t correct_pixel(cfg_t s, pix_in_t px);
    longint dx, dy, t, n;
    logic [63:0] d2, den, c, q, at;
    pix_out_t r;
    dx = longint'(s.frame_width / 2) - longint'(px.pixel_col) - 1;
    dy = longint'(s.frame_height / 2) - longint'(px.pixel_row) - 1;
    d2 = dx * dx + dy * dy;
    den = {24'd0, s.radius_sq} + (d2 << 8);
    c = (den == 0) ? 64'(px.pixel_value) : (64'(px.pixel_value) * s.radius_sq) / den;
    r.out_value = c[15:0];
    r.clamped = 1'b0;
    if (s.depth_cur != s.depth_new || s.offset_cur != s.offset_new) begin
      t = (longint'(s.offset_cur) - longint'(s.offset_new)) * longint'(s.max_intensity);
      n = longint'(c * s.depth_cur) + t;
      if (s.depth_new == 0) begin
        r.out_value = (n > 0) ? VALUE_MAX : 16'd0;
        r.clamped = 1'b1;
      end else begin
        if (n < 0) begin
          q = 0;
          r.clamped = 1'b1;
        end else begin
          q = 64'(n) / s.depth_new;
          if (q > 65535) begin
            q = 65535;
            r.clamped = 1'b1;
          end
        end
        at = (t < 0) ? 64'(-t) : 64'(t);
        // zero rule: exact offset-only quotient maps to zero
        if (at % s.depth_new == 0 && t >= 0 && q == at / s.depth_new) q = 0;
        r.out_value = q[15:0];
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string what);
    $display("mismatch at %0t: %s", $realtime, what);
    fail_count++;
  endtask

  assign pending_count = expected_q.size();

  initial begin
    fail_count = 0;
    beats_seen = 0;
  end

  always @(posedge clk) begin
    pix_out_t exp_beat;
    if (rst) begin
      settings <= '{FRAME_WIDTH_RST, FRAME_HEIGHT_RST, RADIUS_SQ_RST, DEPTH_CUR_RST,
                    OFFSET_CUR_RST, DEPTH_NEW_RST, OFFSET_NEW_RST, MAX_INTENSITY_RST};
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_FRAME_WIDTH:   settings.frame_width   <= cfg_data[10:0];
          REG_FRAME_HEIGHT:  settings.frame_height  <= cfg_data[10:0];
          REG_RADIUS_SQ:     settings.radius_sq     <= cfg_data[39:0];
          REG_DEPTH_CUR:     settings.depth_cur     <= cfg_data[15:0];
          REG_OFFSET_CUR:    settings.offset_cur    <= cfg_data[15:0];
          REG_DEPTH_NEW:     settings.depth_new     <= cfg_data[15:0];
          REG_OFFSET_NEW:    settings.offset_new    <= cfg_data[15:0];
          REG_MAX_INTENSITY: settings.max_intensity <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) expected_q.push_back(correct_pixel(settings, in_data));
      if (out_valid && out_ready) begin
        beats_seen++;
        if (expected_q.size() == 0) begin
          report_mismatch("output beat with nothing expected");
        end else begin
          exp_beat = expected_q.pop_front();
          if (out_data.out_value !== exp_beat.out_value)
            report_mismatch($sformatf("out_value %0d, expected %0d",
                                      out_data.out_value, exp_beat.out_value));
          if (out_data.clamped !== exp_beat.clamped)
            report_mismatch($sformatf("clamped %0b, expected %0b",
                                      out_data.clamped, exp_beat.clamped));
        end
      end
    end
  end
endmodule

@@ tb/sv/tb_tof_depth_pixel_correct_rescale_unit.sv @@
// Testbench top: drives settings and pixel beats, and gives the verdict.
`timescale 1ns / 100ps

module tb_tof_depth_pixel_correct_rescale_unit;
  import dpcr_pkg::*;

  localparam int LATENCY   = 39;
  localparam int N_RANDOM  = 1350;
  localparam int CYCLE_CAP = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [3:0] cfg_index = '0;
  logic [39:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  pix_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  pix_out_t out_data;
  int fail_count, pending_count, beats_seen;
  int cycle_count = 0;
  int pixels_sent = 0;
  bit calm_phase = 0;
  bit hold_off = 0;

  always #1 clk = ~clk;

  tof_depth_pixel_correct_rescale_unit dut (.*);

  dpcr_checker chk (.*);

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_CAP) begin
      $display("[tof_depth_pixel_correct_rescale_unit] ERROR");
      $finish;
    end
  end

  // Receiver: random stall bursts, plus one long hold-off
  initial begin
    int n;
    @(negedge clk);
    while (1) begin
      if (hold_off) begin
        out_ready <= 1'b0;
        repeat (200) @(negedge clk);
        hold_off = 0;
      end else if (!calm_phase && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        n = $urandom_range(1, 16);
        repeat (n) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
        n = $urandom_range(1, 20);
        repeat (n) @(negedge clk);
      end
    end
  end

  task automatic write_reg(reg_idx_t idx, logic [39:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Send one pixel beat, with an optional random gap before it
  task automatic send_pixel(logic [9:0] row, logic [9:0] col, logic [15:0] val);
    int gap;
    if (!calm_phase && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 16);
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{row, col, val};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    pixels_sent++;
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  task automatic write_all(logic [10:0] w, logic [10:0] h, logic [39:0] r, logic [15:0] dc,
                           logic [15:0] oc, logic [15:0] dn, logic [15:0] on,
                           logic [15:0] mx);
    write_reg(REG_FRAME_WIDTH, 40'(w));
    write_reg(REG_FRAME_HEIGHT, 40'(h));
    write_reg(REG_RADIUS_SQ, r);
    write_reg(REG_DEPTH_CUR, 40'(dc));
    write_reg(REG_OFFSET_CUR, 40'(oc));
    write_reg(REG_DEPTH_NEW, 40'(dn));
    write_reg(REG_OFFSET_NEW, 40'(on));
    write_reg(REG_MAX_INTENSITY, 40'(mx));
  endtask

  // Pixels mostly in rows and columns 0 to 63, sometimes anywhere
  task automatic random_pixels(int count);
    for (int i = 0; i < count; i++)
      send_pixel($urandom_range(0, 3) == 0 ? 10'($urandom) : 10'($urandom_range(0, 63)),
                 $urandom_range(0, 3) == 0 ? 10'($urandom) : 10'($urandom_range(0, 63)),
                 16'($urandom));
  endtask

  initial begin
    int per_phase;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: reset settings, rescale skipped, field extremes
    send_pixel(10'd0, 10'd0, 16'd0);
    send_pixel(10'd1023, 10'd1023, 16'hFFFF);
    send_pixel(10'd119, 10'd159, 16'hFFFF);
    send_pixel(10'h2AA, 10'h155, 16'hAAAA);
    send_pixel(10'h155, 10'h2AA, 16'h5555);
    drain();
    // Zero radius on and off the center, zero-sized frame
    write_all(11'd0, 11'd0, 40'd0, 16'd1000, 16'd0, 16'd1000, 16'd0, 16'd65535);
    send_pixel(10'h3FF, 10'h3FF, 16'd1234);
    send_pixel(10'd0, 10'd0, 16'd1234);
    drain();
    write_reg(REG_FRAME_WIDTH, 40'd2);
    write_reg(REG_FRAME_HEIGHT, 40'd2);
    send_pixel(10'd0, 10'd0, 16'hFFFF);
    drain();
    // Negative numerator and zero rule; high saturation
    write_all(11'd1024, 11'd1024, 40'hFF_FFFF_FFFF, 16'd1, 16'd0, 16'd1, 16'd1, 16'd65535);
    send_pixel(10'd511, 10'd511, 16'd0);
    send_pixel(10'd511, 10'd511, 16'hFFFF);
    drain();
    write_all(11'd1024, 11'd1024, 40'hFF_FFFF_FFFF, 16'd65535, 16'd65535, 16'd1, 16'd0, 16'd1);
    send_pixel(10'd511, 10'd511, 16'd0);
    send_pixel(10'd0, 10'd0, 16'hFFFF);
    drain();
    // Zero depth_new with positive and non-positive numerators
    write_all(11'd320, 11'd240, 40'd19660800, 16'd1000, 16'd0, 16'd0, 16'd0, 16'd65535);
    send_pixel(10'd119, 10'd159, 16'd500);
    send_pixel(10'd119, 10'd159, 16'd0);
    drain();
    write_all(11'h7FF, 11'h7FF, 40'd1, 16'd3, 16'd5, 16'd7, 16'd2, 16'd9);
    send_pixel(10'd1000, 10'd2, 16'd300);
    send_pixel(10'd5, 10'd1020, 16'hFFFF);
    drain();

    // Random phases under random settings, with the long receiver hold-off in one
    per_phase = N_RANDOM / 9;
    for (int ph = 0; ph < 9; ph++) begin
      write_all(11'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(1, 128)),
                11'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(1, 128)),
                ph == 0 ? 40'hFF_FFFF_FFFF :
                  ($urandom_range(0, 1) ? {8'($urandom), 32'($urandom)} :
                   40'($urandom_range(1, 1 << 20))),
                16'($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 65535)),
                16'($urandom_range(0, 2) == 0 ? 0 : $urandom),
                16'($urandom_range(0, 5) == 0 ? 0 : $urandom_range(1, 65535)),
                16'($urandom_range(0, 2) == 0 ? 0 : $urandom),
                16'($urandom_range(0, 3) == 0 ? 65535 : $urandom));
      if (ph == 8) calm_phase = 1;
      if (ph == 2) hold_off = 1;
      random_pixels(per_phase);
      drain();
    end

    $display("covered %0d of %0d pixel beats over directed special cases and nine random settings",
             beats_seen, pixels_sent);
    $display("with stall bursts, gaps, and one long output hold-off");
    if (fail_count == 0) begin
      $display("[tof_depth_pixel_correct_rescale_unit] OK");
    end else begin
      $display("[tof_depth_pixel_correct_rescale_unit] ERROR");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
src/dpcr_pkg.sv
src/dpcr_div.sv
src/dpcr_falloff.sv
src/dpcr_rescale.sv
src/tof_depth_pixel_correct_rescale_unit.sv
tb/sv/dpcr_checker.sv
tb/sv/tb_tof_depth_pixel_correct_rescale_unit.sv
